/* sv/kvat_pkg.sv */
// Shared types and codes for the key/value association table.
package kvat_pkg;

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_READ   = 3'd1,
    OP_UPSERT = 3'd2,
    OP_WRITE  = 3'd3,
    OP_APPEND = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] key;
    logic [3:0]  index;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [4:0]  result_index;
    logic [31:0] result_value;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic load_req;
    logic scan_start;
    logic scan;
    logic save_match;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_key_op;
    logic count_zero;
    logic hit;
    logic cmp_last;
    logic out_free;
  } stat_t;

endpackage

/* sv/kvat_ctrl.sv */
// Request sequencer: accept, key scan, index read, finish.
module kvat_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  kvat_pkg::stat_t stat_i,
  output kvat_pkg::cmd_t  cmd_o
);
  import kvat_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req   = 1'b1;
          cmd_o.scan_start = 1'b1;
          if (stat_i.in_key_op && !stat_i.count_zero) begin
            state_d = S_SCAN;
          end else if (stat_i.in_key_op) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit) begin
          cmd_o.save_match = 1'b1;
          state_d          = S_FINISH;
        end else if (stat_i.cmp_last) begin
          state_d = S_FINISH;
        end
      end
      S_READ: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/kvat_dp.sv */
// Table storage, scan pipeline, request and result registers.
module kvat_dp #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kvat_pkg::req_t  in_data_i,
  input  kvat_pkg::cmd_t  cmd_i,
  output kvat_pkg::stat_t stat_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output kvat_pkg::rsp_t  out_data_o
);
  import kvat_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [KEY_BITS-1:0]   key_mem [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem [CAPACITY];

  req_t                  req_q;
  logic [CW-1:0]         count_q, count_d;
  logic [AW-1:0]         ptr_q, cmp_pos_q, match_pos_q;
  logic                  cmp_vld_q, found_q;
  logic [KEY_BITS-1:0]   key_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q, match_val_q;
  logic                  out_valid_q;
  rsp_t                  out_q, rsp_d;

  logic [AW-1:0]         rd_addr, last_addr, wr_addr, idx_addr, cnt_addr;
  logic [KEY_BITS-1:0]   req_key;
  logic                  key_we, val_we, full, in_range;
  logic [VALUE_BITS-1:0] rval;
  logic [2:0]            in_op;

  assign req_key   = KEY_BITS'(req_q.key);
  assign idx_addr  = AW'(req_q.index);
  assign cnt_addr  = AW'(count_q);
  assign last_addr = AW'(count_q - CW'(1));
  assign rd_addr   = cmd_i.scan ? ptr_q : idx_addr;
  assign full      = (count_q == CW'(CAPACITY));
  assign in_range  = ({28'd0, req_q.index} < 32'(count_q))
                  && ({28'd0, req_q.index} < 32'(CAPACITY));

  assign in_op             = in_data_i.opcode;
  assign stat_o.in_key_op  = (in_op == OP_LOOKUP) || (in_op == OP_UPSERT);
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.hit        = cmp_vld_q && (key_rd_q == req_key);
  assign stat_o.cmp_last   = cmp_vld_q && (cmp_pos_q == last_addr);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // result and table update for the finishing word
  always_comb begin
    rsp_d   = '0;
    count_d = count_q;
    key_we  = 1'b0;
    val_we  = 1'b0;
    wr_addr = cnt_addr;
    rval    = '0;
    case (req_q.opcode)
      OP_LOOKUP: begin
        rsp_d.found        = found_q;
        rsp_d.result_index = found_q ? 5'(match_pos_q) : 5'(count_q);
        rval               = found_q ? match_val_q : '0;
      end
      OP_READ: begin
        rsp_d.result_index = 5'(req_q.index);
        if (in_range) begin
          rval = val_rd_q;
        end else begin
          rsp_d.status = ST_RANGE;
        end
      end
      OP_UPSERT, OP_APPEND: begin
        if ((req_q.opcode == OP_UPSERT) && found_q) begin
          rsp_d.found        = 1'b1;
          rsp_d.result_index = 5'(match_pos_q);
          val_we             = 1'b1;
          wr_addr            = match_pos_q;
        end else begin
          rsp_d.result_index = 5'(count_q);
          if (full) begin
            rsp_d.status = ST_FULL;
          end else begin
            key_we  = 1'b1;
            val_we  = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
      end
      OP_WRITE: begin
        rsp_d.result_index = 5'(req_q.index);
        wr_addr            = idx_addr;
        if (in_range) begin
          val_we = 1'b1;
        end else begin
          rsp_d.status = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    rsp_d.result_value = 32'(rval);
    rsp_d.entry_count  = 5'(count_d);
    rsp_d.is_empty     = (count_d == '0);
  end

  always_ff @(posedge clk_i) begin
    key_rd_q <= key_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
    if (cmd_i.finish && key_we) begin
      key_mem[wr_addr] <= req_key;
    end
    if (cmd_i.finish && val_we) begin
      val_mem[wr_addr] <= VALUE_BITS'(req_q.value);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
    if (cmd_i.scan_start) begin
      ptr_q <= '0;
    end else if (cmd_i.scan && (ptr_q != last_addr)) begin
      ptr_q <= ptr_q + AW'(1);
    end
    cmp_pos_q <= ptr_q;
    if (cmd_i.save_match) begin
      match_pos_q <= cmp_pos_q;
      match_val_q <= val_rd_q;
    end
    if (cmd_i.finish) begin
      out_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan && !cmd_i.save_match && !stat_o.cmp_last;
      if (cmd_i.scan_start) begin
        found_q <= 1'b0;
      end else if (cmd_i.save_match) begin
        found_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sv/key_value_association_table.sv */
// Top level of the key/value association table.
// Key/value table of CAPACITY entries kept in insertion order, one request
// word in and one result word out. Lookup and upsert scan the stored
// entries through the key memory's single registered read port, one entry
// per cycle. A key request on an empty table goes straight to finish; a scan
// ends at the first match or after the last stored entry. Index reads, index
// writes and appends pass through the read state instead. One request is in
// work at a time; a finished result sits in the output register, so the next
// request is taken while it waits.
// A full table drops the append with status 1; an index at or past the
// entry count gives status 2 and changes nothing. No clearing pass.
module key_value_association_table #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  kvat_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output kvat_pkg::rsp_t out_data_o
);
  import kvat_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  kvat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kvat_dp #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

/* tb/tb_key_value_association_table.sv */
// Self-checking testbench: directed table plus random requests, checked against fixed results or a table shadow.
`timescale 1ns / 100ps

module tb_key_value_association_table;
  import kvat_pkg::*;

  localparam int         SLOTS        = 16;
  localparam int         RANDOM_WORDS = 450;
  localparam int         PAUSE_AT     = 220;
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  typedef struct {
    logic [2:0]  opcode;
    logic [31:0] key;
    logic [3:0]  index;
    logic [31:0] value;
    int          reps;
    bit          known;
    rsp_t        want;
  } step_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  rsp_t out_data_o;

  // shadow copy of the table contents
  logic [31:0] shadow_keys[SLOTS];
  logic [31:0] shadow_vals[SLOTS];
  int          shadow_count;

  rsp_t pending[$];
  int   mismatch_total;
  bit   calm;

  key_value_association_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int idle_draw();
    if (calm) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic rsp_t typed_rsp(bit f, int idx, logic [31:0] v, int cnt, status_e st);
    rsp_t r;
    r.found        = f;
    r.result_index = 5'(idx);
    r.result_value = v;
    r.entry_count  = 5'(cnt);
    r.is_empty     = (cnt == 0);
    r.status       = st;
    return r;
  endfunction

  // first match wins; a miss gives the count
  function automatic int find_key(logic [31:0] k);
    for (int p = 0; p < shadow_count; p++)
      if (shadow_keys[p] == k) return p;
    return shadow_count;
  endfunction

  function automatic void append_entry(logic [31:0] k, logic [31:0] v, inout rsp_t r);
    r.result_index = 5'(shadow_count);
    if (shadow_count >= SLOTS) begin
      r.status = ST_FULL;
    end else begin
      shadow_keys[shadow_count] = k;
      shadow_vals[shadow_count] = v;
      shadow_count++;
    end
  endfunction

  function automatic rsp_t table_outcome(req_t w);
    rsp_t r;
    int   pos;
    r = '0;
    case (w.opcode)
      OP_LOOKUP: begin
        pos = find_key(w.key);
        r.result_index = 5'(pos);
        if (pos < shadow_count) begin
          r.found        = 1'b1;
          r.result_value = shadow_vals[pos];
        end
      end
      OP_READ: begin
        r.result_index = 5'(w.index);
        if (w.index < shadow_count) r.result_value = shadow_vals[w.index];
        else r.status = ST_RANGE;
      end
      OP_UPSERT: begin
        pos = find_key(w.key);
        if (pos < shadow_count) begin
          r.found        = 1'b1;
          r.result_index = 5'(pos);
          shadow_vals[pos] = w.value;
        end else begin
          append_entry(w.key, w.value, r);
        end
      end
      OP_WRITE: begin
        r.result_index = 5'(w.index);
        if (w.index < shadow_count) shadow_vals[w.index] = w.value;
        else r.status = ST_RANGE;
      end
      OP_APPEND: append_entry(w.key, w.value, r);
      default: ;
    endcase
    r.entry_count = 5'(shadow_count);
    r.is_empty    = (shadow_count == 0);
    return r;
  endfunction

  // valid stays up across back-to-back words; only lowered for a gap
  task automatic send_word(req_t w, int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // result side: random stalls, check every accepted word
  initial begin : result_side
    int   stall;
    rsp_t want;
    @(posedge rst_ni);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word: found=%0d idx=%0d val=%h cnt=%0d empty=%0d st=%0d",
                 $time, out_data_o.found, out_data_o.result_index, out_data_o.result_value,
                 out_data_o.entry_count, out_data_o.is_empty, out_data_o.status);
        mismatch_total++;
      end else begin
        want = pending.pop_front();
        if (out_data_o !== want) begin
          $display("%0t: mismatch expected found=%0d idx=%0d val=%h cnt=%0d empty=%0d st=%0d",
                   $time, want.found, want.result_index, want.result_value,
                   want.entry_count, want.is_empty, want.status);
          $display("%0t:          actual found=%0d idx=%0d val=%h cnt=%0d empty=%0d st=%0d",
                   $time, out_data_o.found, out_data_o.result_index, out_data_o.result_value,
                   out_data_o.entry_count, out_data_o.is_empty, out_data_o.status);
          mismatch_total++;
        end
      end
    end
  end

  initial begin : request_side
    step_row_t rows[13];
    req_t      w;
    rsp_t      predicted;
    int        sel;
    int        drain;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    shadow_count   = 0;
    mismatch_total = 0;
    calm           = 1'b0;

    rows = '{
      '{OP_LOOKUP,   32'h0,         4'd0,  32'h0,         1,  1'b1, typed_rsp(0, 0, 0, 0, ST_OK)},
      '{OP_READ,     32'h0,         4'd15, 32'hFFFF_FFFF, 1,  1'b1,
        typed_rsp(0, 15, 0, 0, ST_RANGE)},
      '{OP_WRITE,    32'hFFFF_FFFF, 4'd0,  32'hFFFF_FFFF, 1,  1'b1,
        typed_rsp(0, 0, 0, 0, ST_RANGE)},
      '{OP_SPARE_HI, 32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 1,  1'b1, typed_rsp(0, 0, 0, 0, ST_OK)},
      '{OP_APPEND,   32'hFFFF_FFFF, 4'd0,  32'hFFFF_FFFF, 1,  1'b1, typed_rsp(0, 0, 0, 1, ST_OK)},
      // upsert miss appends, then upsert hit overwrites in place
      '{OP_UPSERT,   32'h0,         4'd0,  32'h0,         1,  1'b1, typed_rsp(0, 1, 0, 2, ST_OK)},
      '{OP_UPSERT,   32'hFFFF_FFFF, 4'd15, 32'h7FFF_FFFE, 1,  1'b1, typed_rsp(1, 0, 0, 2, ST_OK)},
      // duplicate key: lookup must still return the first one
      '{OP_APPEND,   32'hFFFF_FFFF, 4'd0,  32'h8000_0001, 1,  1'b1, typed_rsp(0, 2, 0, 3, ST_OK)},
      '{OP_LOOKUP,   32'hFFFF_FFFF, 4'd0,  32'h0,         1,  1'b1,
        typed_rsp(1, 0, 32'h7FFF_FFFE, 3, ST_OK)},
      '{OP_APPEND,   32'h100,       4'd0,  32'hC0DE_0000, 13, 1'b0, '0},
      '{OP_APPEND,   32'h5,         4'd0,  32'h1,         1,  1'b1,
        typed_rsp(0, 16, 0, 16, ST_FULL)},
      '{OP_UPSERT,   32'h6,         4'd0,  32'h2,         1,  1'b1,
        typed_rsp(0, 16, 0, 16, ST_FULL)},
      '{OP_LOOKUP,   32'h10C,       4'd0,  32'h0,         1,  1'b0, '0}
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      for (int r = 0; r < rows[i].reps; r++) begin
        w.opcode = rows[i].opcode;
        w.key    = rows[i].key + r;
        w.index  = rows[i].index;
        w.value  = rows[i].value + r;
        send_word(w, idle_draw());
        predicted = table_outcome(w);
        pending.push_back(rows[i].known ? rows[i].want : predicted);
      end
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 100 && n < 160) || (n >= 330 && n < 380);
      if (n == PAUSE_AT) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        while (pending.size() != 0) @(posedge clk_i);
      end
      sel = $urandom_range(0, 19);
      if (sel < 6) w.opcode = OP_LOOKUP;
      else if (sel < 9) w.opcode = OP_READ;
      else if (sel < 13) w.opcode = OP_UPSERT;
      else if (sel < 16) w.opcode = OP_WRITE;
      else if (sel < 19) w.opcode = OP_APPEND;
      else w.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      // mostly keys already in the table, so most lookups and upserts hit across the table
      if (shadow_count > 0 && $urandom_range(0, 3) != 0)
        w.key = shadow_keys[$urandom_range(0, shadow_count - 1)];
      else
        w.key = $urandom;
      w.index = 4'($urandom_range(0, 15));
      w.value = $urandom;
      send_word(w, idle_draw());
      pending.push_back(table_outcome(w));
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    calm = 1'b0;
    drain = 0;
    while (pending.size() != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (40) @(posedge clk_i);
    if (pending.size() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time, pending.size());
      mismatch_total++;
    end
    if (mismatch_total == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
